FILE: sv/pli_pkg.sv
// shared types and constants for the positional list block
package pli_pkg;

  // field widths of the input and result words
  localparam int OP_W    = 2;
  localparam int POS_W   = 8;
  localparam int VALUE_W = 32;
  localparam int ST_W    = 2;

  // packed word widths, rounded up to whole bytes
  localparam int IN_FIELDS_W  = OP_W + POS_W + VALUE_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = VALUE_W + ST_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // default list depth
  localparam int DEF_CAPACITY = 16;

  // operation codes, code 3 is unused
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

endpackage

FILE: sv/positional_list_insert_remove.sv
// positional list: insert, remove and get at a position over a row of shifting cells
//
// Input channel s_tvalid/s_tready/s_tdata carries one operation word:
// an insert, remove or get at a zero-based position. Output channel
// m_tvalid/m_tready/m_tdata carries exactly one result word per input
// word: the removed or read value (zero for an insert and for errors)
// and a status (ok, list empty, invalid position, list full).
// The accepted word is held in an input register, then decoded,
// checked and applied to the list in one pass that loads the result
// register. Throughput is one word per cycle while m_tready stays
// high; the list cells all shift in parallel, so each operation
// completes in the single pass regardless of position or list length.
// Reset empties the list (entry count zero) and drops any word in
// flight. When the receiver stalls, the result register holds its
// word, the input register fills behind it, and s_tready then drops
// until m_tready returns; nothing is lost or repeated.
module positional_list_insert_remove #(
  parameter int CAPACITY = pli_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata, low bit up: operation[2], position[8], value[32], zero fill
  input  logic [pli_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // m_tdata, low bit up: result_value[32], status[2], zero fill
  output logic [pli_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready
);
  import pli_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // input register
  logic                      in_valid;
  logic [OP_W-1:0]           in_op;
  logic [POS_W-1:0]          in_pos;
  logic signed [VALUE_W-1:0] in_value;

  // list state
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic signed [VALUE_W-1:0] cells      [CAPACITY];
  logic signed [VALUE_W-1:0] cells_next [CAPACITY];

  // result register
  logic signed [VALUE_W-1:0] result_value;
  logic signed [VALUE_W-1:0] result_value_next;
  status_t                   status;
  status_t                   status_next;

  logic                      out_load;
  logic                      in_load;
  logic [CMP_W-1:0]          pos_ext;
  logic [CMP_W-1:0]          cnt_ext;
  logic                      is_full;
  logic                      is_empty;
  logic signed [VALUE_W-1:0] rd_value;
  logic                      do_insert;
  logic                      do_remove;

  // handshake: result register frees when empty or taken
  assign out_load = in_valid && (!m_tvalid || m_tready);
  assign in_load  = !in_valid || !m_tvalid || m_tready;
  assign s_tready = in_load;

  // capture the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && s_tvalid) begin
      in_op    <= s_tdata[OP_W-1:0];
      in_pos   <= s_tdata[OP_W +: POS_W];
      in_value <= s_tdata[OP_W + POS_W +: VALUE_W];
    end
  end

  // position checks and the read mux
  assign pos_ext  = CMP_W'(in_pos);
  assign cnt_ext  = CMP_W'(count);
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);
  assign rd_value = cells[in_pos[IDX_W-1:0]];

  // status and result decode
  always_comb begin
    status_next       = ST_OK;
    result_value_next = '0;
    do_insert         = 1'b0;
    do_remove         = 1'b0;
    case (in_op)
      OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_next = ST_BADPOS;
        end else if (is_full) begin
          status_next = ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_next = ST_BADPOS;
        end else begin
          result_value_next = rd_value;
          do_remove         = 1'b1;
        end
      end
      OP_GET: begin
        if (pos_ext >= cnt_ext) begin
          status_next = ST_BADPOS;
        end else begin
          result_value_next = rd_value;
        end
      end
      default: begin
        status_next = ST_BADPOS;
      end
    endcase
  end

  // each cell picks its neighbor, the new value, or holds
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_next[i] = cells[i];
      if (do_insert) begin
        if (CMP_W'(i) == pos_ext) begin
          cells_next[i] = in_value;
        end else if (i > 0 && CMP_W'(i) > pos_ext) begin
          cells_next[i] = cells[(i > 0) ? i - 1 : 0];
        end
      end else if (do_remove) begin
        if (i < CAPACITY - 1 && CMP_W'(i) >= pos_ext) begin
          cells_next[i] = cells[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // entry count update
  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + CNT_W'(1);
    end else if (do_remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  // list state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (out_load) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_value <= result_value_next;
      status       <= status_next;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, status, result_value};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    out_load && do_insert |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_error_holds: assert property (@(posedge clk) disable iff (rst)
    out_load && status_next != ST_OK |=> $stable(count))
    else $error("failed operation changed the list length");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != ST_OK |-> result_value == '0)
    else $error("error result carries a nonzero value");

endmodule

FILE: test/positional_list_insert_remove_tb.sv
// self-checking testbench for the positional list block
`timescale 1ns / 1ps

module positional_list_insert_remove_tb;
  import pli_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 88;
  localparam int MAX_IDLE = 12;
  // operation code 3 has no meaning, the block must flag it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // expected list contents and the results they imply
  class list_scoreboard;
    logic [VALUE_W-1:0] cells[$];
    logic [VALUE_W-1:0] want_value[$];
    status_t want_status[$];
    int errors;
    int words_in;
    int words_out;
    int status_seen[4];

    function int length();
      return cells.size();
    endfunction

    function int pending();
      return want_value.size();
    endfunction

    // apply one accepted operation word to the list
    function void note_word(logic [IN_DATA_W-1:0] word);
      logic [OP_W-1:0] op;
      int unsigned pos;
      logic [VALUE_W-1:0] val;
      logic [VALUE_W-1:0] res;
      status_t st;
      op = word[OP_W-1:0];
      pos = word[OP_W +: POS_W];
      val = word[OP_W + POS_W +: VALUE_W];
      res = '0;
      st = ST_OK;
      case (op)
        OP_INSERT: begin
          if (pos > cells.size()) st = ST_BADPOS;
          else if (cells.size() >= CAPACITY) st = ST_FULL;
          else if (pos == cells.size()) cells.push_back(val);
          else cells.insert(pos, val);
        end
        OP_REMOVE: begin
          if (cells.size() == 0) st = ST_EMPTY;
          else if (pos >= cells.size()) st = ST_BADPOS;
          else begin
            res = cells[pos];
            cells.delete(pos);
          end
        end
        OP_GET: begin
          if (pos >= cells.size()) st = ST_BADPOS;
          else res = cells[pos];
        end
        default: st = ST_BADPOS;
      endcase
      want_value.push_back(res);
      want_status.push_back(st);
      words_in++;
    endfunction

    // compare one result word with the oldest expectation
    function void check_word(logic [OUT_DATA_W-1:0] word);
      logic [VALUE_W-1:0] got_value;
      status_t got_status;
      logic [VALUE_W-1:0] exp_value;
      status_t exp_status;
      got_value = word[VALUE_W-1:0];
      got_status = status_t'(word[VALUE_W +: ST_W]);
      words_out++;
      status_seen[got_status]++;
      if (want_value.size() == 0) begin
        $error("result word with nothing expected: %h", word);
        errors++;
        return;
      end
      exp_value = want_value.pop_front();
      exp_status = want_status.pop_front();
      if (got_value !== exp_value) begin
        $error("result_value: expected %0d, got %0d", $signed(exp_value), $signed(got_value));
        errors++;
      end
      if (got_status !== exp_status) begin
        $error("status: expected %0d, got %0d", exp_status, got_status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  // low bit up: operation[2], position[8], value[32], zero fill
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // low bit up: result_value[32], status[2], zero fill
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;

  list_scoreboard sb = new();
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_wait = 0;
  int cycles = 0;

  positional_list_insert_remove #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // watch both handshakes, draw the next receiver stall per result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_word(m_tdata);
      rx_wait = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    end
    if (!rst && s_tvalid && s_tready) sb.note_word(s_tdata);
  end

  // receiver ready with random stalls
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      m_tready = 1'b0;
      rx_wait--;
    end else begin
      m_tready = 1'b1;
    end
  end

  // present one word after a random gap and hold it until accepted
  task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VALUE_W-1:0] val);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    repeat (gap) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = '0;
    s_tdata[OP_W-1:0] = op;
    s_tdata[OP_W +: POS_W] = pos;
    s_tdata[OP_W + POS_W +: VALUE_W] = val;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // one random word, mostly at valid positions of the current list
  task automatic random_word(input int ins_pct, input int rem_pct);
    int len;
    int roll;
    int pick;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic [VALUE_W-1:0] val;
    len = sb.length();
    roll = $urandom_range(0, 99);
    if (roll < 4) op = OP_UNUSED;
    else if (roll < 4 + ins_pct) op = OP_INSERT;
    else if (roll < 4 + ins_pct + rem_pct) op = OP_REMOVE;
    else op = OP_GET;
    pick = $urandom_range(0, 99);
    if (pick < 12) pos = POS_W'($urandom_range(0, 255));
    else if (pick < 18) pos = POS_W'(len);
    else if (op == OP_INSERT) pos = POS_W'($urandom_range(0, len));
    else pos = POS_W'((len == 0) ? 0 : $urandom_range(0, len - 1));
    pick = $urandom_range(0, 99);
    if (pick < 5) val = 32'h8000_0000;
    else if (pick < 10) val = 32'h7fff_ffff;
    else if (pick < 13) val = '1;
    else if (pick < 15) val = '0;
    else val = $urandom();
    send_word(op, pos, val);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // error cases on the empty list
    send_word(OP_GET, 8'd0, 32'd5);
    send_word(OP_REMOVE, 8'd255, '1);
    send_word(OP_INSERT, 8'd1, 32'd1);
    send_word(OP_UNUSED, 8'd0, 32'd9);
    // extremes at both ends, then read back and remove from the middle
    send_word(OP_INSERT, 8'd0, 32'h8000_0000);
    send_word(OP_INSERT, 8'd1, 32'h7fff_ffff);
    send_word(OP_INSERT, 8'd0, '1);
    send_word(OP_GET, 8'd2, 32'd0);
    send_word(OP_REMOVE, 8'd1, 32'd0);
    send_word(OP_REMOVE, 8'd2, 32'd0);
    send_word(OP_GET, 8'd255, 32'd0);
    // fill up at scattered positions
    while (sb.length() < CAPACITY)
      send_word(OP_INSERT, POS_W'($urandom_range(0, sb.length())), $urandom());
    send_word(OP_INSERT, POS_W'(CAPACITY), 32'd3);
    send_word(OP_INSERT, POS_W'(CAPACITY + 1), 32'd4);
    send_word(OP_REMOVE, POS_W'(CAPACITY - 1), 32'd0);
    send_word(OP_REMOVE, 8'd0, 32'd0);
    drain_results();

    // random phases: fill heavy, drain heavy, mixed, under all idle modes
    for (int p = 0; p < PHASES; p++) begin
      tx_idle = p[0];
      rx_idle = p[1];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        case (p % 3)
          0: random_word(60, 20);
          1: random_word(20, 60);
          default: random_word(35, 30);
        endcase
      end
      drain_results();
    end

    repeat (10) @(negedge clk);
    $display("ran %0d operation words, %0d results back", sb.words_in, sb.words_out);
    $display("status mix: ok %0d, empty %0d, bad position %0d, full %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_BADPOS], sb.status_seen[ST_FULL]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
